>>> rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared status and function codes for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO      = 3'd1;
  localparam logic [2:0] ST_OOM       = 3'd2;
  localparam logic [2:0] ST_NOT_START = 3'd3;
  localparam logic [2:0] ST_DOUBLE    = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

endpackage

>>> rtl/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit allocator over one arena with split on allocate and coalesce on
// free; the block table lives in a RAM of MAX_BLOCKS entries.
// ----------------------------------------------------------------------------
// One item at a time. Each item walks the block table in the RAM one entry per
// cycle through the registered read port to find the target, then walks it
// again to shift entries for a split or to compact the table on a merge, and
// once more to total the free space. The single RAM read port sets the walk
// rate, and no new item is accepted until all walks of the last one are done.
// ALIGN_BYTES must be a power of two. Writing arena_size resets the table at
// once (entry 0 and the count only, no clearing pass). The result is held in an
// output register, so the next item may be accepted while a result waits; a
// second finished result waits inside the block, and the input stalls meanwhile.
module first_fit_block_allocator_core
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS  = 64,
  parameter int ALIGN_BYTES = 256,
  parameter int ADDR_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] request_size,
  input  logic [31:0] free_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] alloc_offset,
  output logic [31:0] total_free,
  output logic [31:0] largest_free
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = IW + 1;
  localparam int EW = 65;
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
  localparam logic [32:0] ALIGNW = 33'(ALIGN_BYTES);
  localparam logic [32:0] AMASK = 33'(ALIGN_BYTES - 1);
  localparam logic [32:0] ADDR_LIM = (ADDR_BITS >= 33) ? {33{1'b1}} :
                                     33'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [31:0] LMASK = ADDR_LIM[31:0];

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_SHIFT, S_MERGE, S_STATS, S_DONE
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] rd_idx;
  logic          rd_ok;
  logic [IW-1:0] hit;
  logic          is_free_op;
  logic [32:0]   rounded;
  logic [31:0]   off_q;
  logic [31:0]   carry_start;
  logic [31:0]   carry_len;
  logic          carry_free;
  logic          carry_ok;
  logic [CW-1:0] widx;
  logic [2:0]    st_q;
  logic [31:0]   where_q;
  logic [31:0]   tot_q;
  logic [31:0]   big_q;

  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [IW-1:0] raddr;
  logic [EW-1:0] rdata;
  logic [31:0]   r_start;
  logic [31:0]   r_len;
  logic          r_free;

  assign r_start = rdata[64:33];
  assign r_len   = rdata[32:1];
  assign r_free  = rdata[0];

  // read address follows the walk index; the registered read data belongs to entry rd_idx
  assign raddr = IW'(idx);

  ffba_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [32:0] req_w;
  logic [32:0] rnd_sum;
  logic        rnd_oom;
  assign req_w = {1'b0, request_size};
  assign rnd_sum = (req_w & ~AMASK) + (((req_w & AMASK) != '0) ? ALIGNW : '0);
  assign rnd_oom = rnd_sum > ADDR_LIM;

  logic [32:0] tail;
  logic        fits;
  logic        split;
  logic        full;
  logic        f_hit;
  logic        rd_is_hit;
  logic        absorb;
  logic        pass_end;
  logic [31:0] split_start;
  logic [31:0] merged_len;

  assign tail = {1'b0, r_len} - rounded;
  assign fits = r_free && ({1'b0, r_len} >= rounded);
  assign split = tail >= ALIGNW;
  assign full = count >= MAXC;
  assign f_hit = rd_ok && (is_free_op ? (r_start == off_q) : fits);
  assign rd_is_hit = (IW'(rd_idx) == hit);
  assign absorb = carry_ok && carry_free && (r_free || rd_is_hit);
  assign pass_end = !rd_ok && (idx > count);
  assign split_start = (r_start + rounded[31:0]) & LMASK;
  assign merged_len = (carry_len + r_len) & LMASK;

  assign in_stall = (state != S_IDLE) || cfg_we;

  always_comb begin
    we = 1'b0;
    waddr = IW'(rd_idx);
    wdata = {carry_start, carry_len, carry_free};
    case (state)
      S_IDLE: begin
        if (cfg_we) begin
          we = 1'b1;
          waddr = '0;
          wdata = {32'd0, cfg_wdata, 1'b1};
        end
      end
      S_FIND: begin
        if (f_hit && !is_free_op && !(split && full)) begin
          we = 1'b1;
          wdata = {r_start, split ? rounded[31:0] : r_len, 1'b0};
        end
      end
      S_SHIFT: begin
        if (rd_ok) begin
          we = 1'b1;
        end else if (pass_end) begin
          we = 1'b1;
          waddr = IW'(count);
        end
      end
      S_MERGE: begin
        if (rd_ok) begin
          if (!absorb && carry_ok) begin
            we = 1'b1;
            waddr = IW'(widx);
          end
        end else if (pass_end) begin
          we = 1'b1;
          waddr = IW'(widx);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      if (state == S_DONE) begin
        if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          status <= st_q;
          alloc_offset <= where_q;
          total_free <= tot_q;
          largest_free <= big_q;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_we) begin
            count <= (cfg_wdata != '0) ? CW'(1) : '0;
          end else if (in_valid && !in_stall) begin
            is_free_op <= func;
            off_q <= free_offset;
            rounded <= rnd_sum;
            where_q <= '0;
            idx <= '0;
            rd_idx <= '0;
            rd_ok <= 1'b0;
            tot_q <= '0;
            big_q <= '0;
            if (func == FUNC_ALLOC && request_size == '0) begin
              st_q <= ST_ZERO;
              state <= S_STATS;
            end else if (func == FUNC_ALLOC && rnd_oom) begin
              st_q <= ST_OOM;
              state <= S_STATS;
            end else begin
              st_q <= (func == FUNC_FREE) ? ST_NOT_START : ST_OOM;
              state <= S_FIND;
            end
          end
        end
        S_FIND: begin
          if (f_hit) begin
            rd_ok <= 1'b0;
            if (is_free_op) begin
              idx <= '0;
              if (r_free) begin
                st_q <= ST_DOUBLE;
                state <= S_STATS;
              end else begin
                st_q <= ST_OK;
                hit <= IW'(rd_idx);
                widx <= '0;
                carry_ok <= 1'b0;
                state <= S_MERGE;
              end
            end else if (split && full) begin
              idx <= '0;
              st_q <= ST_FULL;
              state <= S_STATS;
            end else begin
              st_q <= ST_OK;
              where_q <= r_start;
              if (split) begin
                carry_start <= split_start;
                carry_len <= tail[31:0];
                carry_free <= 1'b1;
                idx <= rd_idx + CW'(1);
                state <= S_SHIFT;
              end else begin
                idx <= '0;
                state <= S_STATS;
              end
            end
          end else if (pass_end) begin
            idx <= '0;
            state <= S_STATS;
          end else begin
            rd_ok <= (idx < count);
            rd_idx <= idx;
            idx <= idx + CW'(1);
          end
        end
        S_SHIFT: begin
          // write the carried entry where the read one was, carry the read one up
          if (rd_ok) begin
            carry_start <= r_start;
            carry_len <= r_len;
            carry_free <= r_free;
          end
          if (pass_end) begin
            count <= count + CW'(1);
            idx <= '0;
            state <= S_STATS;
          end else begin
            rd_ok <= (idx < count);
            rd_idx <= idx;
            idx <= idx + CW'(1);
          end
        end
        S_MERGE: begin
          // compact in order, folding free runs into one entry
          if (rd_ok) begin
            if (absorb) begin
              carry_len <= merged_len;
            end else begin
              if (carry_ok) widx <= widx + CW'(1);
              carry_ok <= 1'b1;
              carry_start <= r_start;
              carry_len <= r_len;
              carry_free <= r_free || rd_is_hit;
            end
          end
          if (pass_end) begin
            count <= widx + CW'(1);
            idx <= '0;
            state <= S_STATS;
          end else begin
            rd_ok <= (idx < count);
            rd_idx <= idx;
            idx <= idx + CW'(1);
          end
        end
        S_STATS: begin
          if (rd_ok && r_free) begin
            tot_q <= tot_q + r_len;
            if (r_len > big_q) big_q <= r_len;
          end
          if (pass_end) begin
            state <= S_DONE;
          end else begin
            rd_ok <= (idx < count);
            rd_idx <= idx;
            idx <= idx + CW'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= MAXC)
    else $error("block count above table size");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(status) && $stable(alloc_offset) &&
                                  $stable(total_free) && $stable(largest_free)))
    else $error("stalled result changed");

endmodule
